FILE: rtl/x86_privileged_opcode_detector_top_macros.svh
// Assertion macros used by the privileged opcode detector parser.
`ifndef X86_PRIVILEGED_OPCODE_DETECTOR_TOP_MACROS_SVH
`define X86_PRIVILEGED_OPCODE_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk and idle while reset is held.
`define X86POD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("x86pod: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and idle while reset is held.
`define X86POD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("x86pod: next-cycle check failed");

`endif

FILE: rtl/x86pod_pkg.sv
// Package with the word types and opcode classification functions of the detector.
`timescale 1ns / 1ps

package x86pod_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 5;
    localparam int PFX_W   = 4;

    typedef struct packed {
        logic [BYTE_W-1:0] instr_byte;
        logic              start_req;
    } t_in_word;

    typedef struct packed {
        logic               privileged;
        logic               too_many_prefixes;
        logic [COUNT_W-1:0] bytes_used;
    } t_out_word;

    localparam logic [BYTE_W-1:0] OP_ESCAPE = 8'h0F;
    localparam logic [BYTE_W-1:0] OP_HLT    = 8'hF4;
    localparam logic [BYTE_W-1:0] OP_CLI    = 8'hFA;
    localparam logic [BYTE_W-1:0] OP_STI    = 8'hFB;
    localparam logic [BYTE_W-1:0] OP2_GRP6  = 8'h00;
    localparam logic [BYTE_W-1:0] OP2_GRP7  = 8'h01;
    localparam logic [BYTE_W-1:0] OP2_ESC38 = 8'h38;
    localparam logic [BYTE_W-1:0] OP2_GRP9  = 8'hC7;

    // Segment, size, LOCK, REP and REX prefixes.
    function automatic logic is_prefix(input logic [BYTE_W-1:0] b);
        logic r;
        case (b) inside
            [8'h40:8'h4F],
            8'h26, 8'h2E, 8'h36, 8'h3E,
            8'h64, 8'h65, 8'h66, 8'h67,
            8'hF0, 8'hF2, 8'hF3: r = 1'b1;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic first_is_privileged(input logic [BYTE_W-1:0] b);
        return (b == OP_HLT) || (b == OP_CLI) || (b == OP_STI);
    endfunction

    function automatic logic second_is_privileged(input logic [BYTE_W-1:0] b);
        logic r;
        case (b) inside
            8'h06, 8'h07, 8'h08, 8'h09,
            8'h20, 8'h21, 8'h22, 8'h23,
            8'h30, 8'h32, 8'h33, 8'h35,
            8'h78, 8'h79: r = 1'b1;
            default:      r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic second_needs_third(input logic [BYTE_W-1:0] b);
        return (b == OP2_GRP6) || (b == OP2_GRP7) || (b == OP2_ESC38) || (b == OP2_GRP9);
    endfunction

    function automatic logic third_is_privileged(input logic [BYTE_W-1:0] sec,
                                                 input logic [BYTE_W-1:0] b);
        logic [2:0] modrm_reg;
        logic       r;
        modrm_reg = b[5:3];
        case (sec)
            OP2_GRP6: r = (modrm_reg == 3'd2) || (modrm_reg == 3'd3);
            OP2_GRP7: begin
                case (b) inside
                    8'hC1, 8'hC2, 8'hC3, 8'hC4,
                    8'hC8, 8'hC9, 8'hD1, 8'hF8: r = 1'b1;
                    default: r = (modrm_reg == 3'd2) || (modrm_reg == 3'd3) ||
                                 (modrm_reg == 3'd6) || (modrm_reg == 3'd7);
                endcase
            end
            OP2_ESC38: r = (b == 8'h80) || (b == 8'h81);
            OP2_GRP9:  r = (modrm_reg == 3'd6) || (modrm_reg == 3'd7);
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/x86pod_in_stage.sv
// Input register holding one instruction byte word ahead of the parser.
`timescale 1ns / 1ps

module x86pod_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  x86pod_pkg::t_in_word i_word,
    input  logic               i_take,
    output logic               o_valid,
    output x86pod_pkg::t_in_word o_word
);

    logic                 r_valid;
    x86pod_pkg::t_in_word r_word;

    // The slot frees itself in the same cycle the parser takes its word.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

FILE: rtl/x86pod_parser.sv
// Prefix and opcode parser with its phase state and the result register.
`timescale 1ns / 1ps
`include "x86_privileged_opcode_detector_top_macros.svh"

module x86pod_parser #(
    parameter int MAX_PREFIXES = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  x86pod_pkg::t_in_word  i_word,
    output logic                  o_take,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output x86pod_pkg::t_out_word o_out_word
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_OPCODE = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;
    localparam logic [1:0] PH_THIRD  = 2'd3;

    localparam logic [x86pod_pkg::PFX_W-1:0] PfxLimit = x86pod_pkg::PFX_W'(MAX_PREFIXES);

    logic [1:0]                          r_phase, n_phase;
    logic [x86pod_pkg::PFX_W-1:0]        r_pfx_cnt, n_pfx_cnt;
    logic [x86pod_pkg::BYTE_W-1:0]       r_second, n_second;
    logic [x86pod_pkg::COUNT_W-1:0]      r_byte_cnt, n_byte_cnt;
    logic                                r_out_valid;
    x86pod_pkg::t_out_word               r_out_word;

    logic [1:0]                          cur_phase;
    logic [x86pod_pkg::PFX_W-1:0]        cur_pfx_cnt;
    logic [x86pod_pkg::BYTE_W-1:0]       cur_second;
    logic [x86pod_pkg::COUNT_W-1:0]      cur_byte_cnt;
    logic [x86pod_pkg::BYTE_W-1:0]       b;
    logic                                emit;
    logic                                v_priv;
    logic                                v_tmp;

    assign o_take      = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign b           = i_word.instr_byte;

    always_comb begin
        // A start word restarts the parse before the byte is looked at.
        cur_phase    = i_word.start_req ? PH_OPCODE : r_phase;
        cur_pfx_cnt  = i_word.start_req ? '0 : r_pfx_cnt;
        cur_second   = i_word.start_req ? '0 : r_second;
        cur_byte_cnt = i_word.start_req ? '0 : r_byte_cnt;

        n_phase    = cur_phase;
        n_pfx_cnt  = cur_pfx_cnt;
        n_second   = cur_second;
        n_byte_cnt = cur_byte_cnt;
        emit       = 1'b0;
        v_priv     = 1'b0;
        v_tmp      = 1'b0;

        if (cur_phase != PH_IDLE) begin
            n_byte_cnt = cur_byte_cnt + x86pod_pkg::COUNT_W'(1);
        end

        unique case (cur_phase)
            PH_IDLE: begin
            end
            PH_OPCODE: begin
                if (x86pod_pkg::is_prefix(b)) begin
                    n_pfx_cnt = cur_pfx_cnt + x86pod_pkg::PFX_W'(1);
                    if (n_pfx_cnt >= PfxLimit) begin
                        emit  = 1'b1;
                        v_tmp = 1'b1;
                    end
                end else if (x86pod_pkg::first_is_privileged(b)) begin
                    emit   = 1'b1;
                    v_priv = 1'b1;
                end else if (b == x86pod_pkg::OP_ESCAPE) begin
                    n_phase = PH_SECOND;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_SECOND: begin
                if (x86pod_pkg::second_is_privileged(b)) begin
                    emit   = 1'b1;
                    v_priv = 1'b1;
                end else if (x86pod_pkg::second_needs_third(b)) begin
                    n_second = b;
                    n_phase  = PH_THIRD;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_THIRD: begin
                emit   = 1'b1;
                v_priv = x86pod_pkg::third_is_privileged(cur_second, b);
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (emit) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pfx_cnt   <= '0;
            r_second    <= '0;
            r_byte_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase    <= n_phase;
                r_pfx_cnt  <= n_pfx_cnt;
                r_second   <= n_second;
                r_byte_cnt <= n_byte_cnt;
            end
            if (o_take && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_out_word.privileged        <= v_priv;
            r_out_word.too_many_prefixes <= v_tmp;
            r_out_word.bytes_used        <= n_byte_cnt;
        end
    end

    `X86POD_ASSERT_SAME(a_tmp_not_priv, r_out_valid && r_out_word.too_many_prefixes, !r_out_word.privileged)
    `X86POD_ASSERT_SAME(a_bytes_nonzero, r_out_valid, r_out_word.bytes_used != '0)
    `X86POD_ASSERT_NEXT(a_idle_after_verdict, o_take && emit, r_phase == PH_IDLE && r_out_valid)
    `X86POD_ASSERT_SAME(a_pfx_within_limit, 1'b1, r_pfx_cnt <= PfxLimit)

endmodule

FILE: rtl/x86_privileged_opcode_detector_top.sv
// Top level of the x86 privileged opcode detector.
`timescale 1ns / 1ps

// The detector takes an x86 instruction stream one byte per input word on a
// valid/ready channel (i_in_valid, o_in_ready, i_instr_byte, i_start_req). A
// word with i_start_req set begins a new instruction and drops any parse in
// progress. Prefix bytes are skipped; the opcode bytes are then classified.
// Each instruction not cut short by a new start yields one result word on the
// output channel (o_out_valid, i_out_ready, o_privileged, o_too_many_prefixes,
// o_bytes_used), issued for the byte that settles the verdict. Bytes that
// arrive after a verdict and before the next start produce no result.
// A byte accepted into the input register is parsed from it, and its result is
// captured in the output register and offered on o_out_valid. Throughput is
// one byte per cycle while the receiver does not stall, set by the parse that
// lies combinationally between the two registers.
// When the receiver stalls, the result word is held in the output register and
// the input register keeps one further word; only then does o_in_ready drop.
// Synchronous reset empties both registers and returns the parser to idle, so
// bytes without a start are ignored until the first start word arrives.
// MAX_PREFIXES (1 to 15) sets the prefix count at which an instruction is
// reported as not privileged with the too-many-prefixes flag.

module x86_privileged_opcode_detector_top #(
    parameter int MAX_PREFIXES = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_instr_byte,
    input  logic       i_start_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_privileged,
    output logic       o_too_many_prefixes,
    output logic [4:0] o_bytes_used
);

    x86pod_pkg::t_in_word  in_word;
    x86pod_pkg::t_in_word  held_word;
    x86pod_pkg::t_out_word out_word;
    logic                  held_valid;
    logic                  take;

    assign in_word.instr_byte = i_instr_byte;
    assign in_word.start_req  = i_start_req;

    // One-word input register in front of the parser.
    x86pod_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (in_word),
        .i_take  (take),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    // Parse state, classification and the result register.
    x86pod_parser #(
        .MAX_PREFIXES (MAX_PREFIXES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_word      (held_word),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (out_word)
    );

    assign o_privileged        = out_word.privileged;
    assign o_too_many_prefixes = out_word.too_many_prefixes;
    assign o_bytes_used        = out_word.bytes_used;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the x86 privileged opcode detector top level.
`timescale 1ns / 1ps

module tb;

    // The detector is built with the full prefix limit of fifteen.
    localparam int MAX_PFX        = 15;
    localparam int HOLD_CYCLES    = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 250;
    localparam int GAP_CAP        = 100;

    // Parse state of the local decoder.
    localparam logic [1:0] PS_IDLE   = 2'd0;
    localparam logic [1:0] PS_OPCODE = 2'd1;
    localparam logic [1:0] PS_SECOND = 2'd2;
    localparam logic [1:0] PS_THIRD  = 2'd3;

    logic       i_clk               = 1'b0;
    logic       i_rst_n             = 1'b0;
    logic       i_in_valid          = 1'b0;
    logic [7:0] i_instr_byte        = 8'h00;
    logic       i_start_req         = 1'b0;
    logic       i_out_ready         = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_privileged;
    logic       o_too_many_prefixes;
    logic [4:0] o_bytes_used;

    x86_privileged_opcode_detector_top #(
        .MAX_PREFIXES(MAX_PFX)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_instr_byte       (i_instr_byte),
        .i_start_req        (i_start_req),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_privileged       (o_privileged),
        .o_too_many_prefixes(o_too_many_prefixes),
        .o_bytes_used       (o_bytes_used)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Verdicts the decoder has predicted and the block has not yet delivered.
    x86pod_pkg::t_out_word verdict_q[$];

    // Local copy of the parser state.
    logic [1:0]   pstate     = PS_IDLE;
    logic [3:0]   pfx_seen   = '0;
    logic [7:0]   esc_second = '0;
    logic [4:0]   consumed   = '0;

    // Idling controls, changed between phases by the test tasks.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_req           = 1'b0;
    int hold_left          = 0;

    int errors        = 0;
    int sent_words    = 0;
    int parsed_words  = 0;
    int instr_count   = 0;
    int verdicts_seen = 0;
    int priv_seen     = 0;
    int overflow_seen = 0;
    int max_used_seen = 0;
    int idle_cycles   = 0;

    // ------------------------------------------------------------------
    // Opcode classification, written independently of the RTL package.
    // ------------------------------------------------------------------

    // REX bytes fill the whole 0x40 to 0x4F row; the legacy prefixes are
    // the segment overrides, the two size overrides, LOCK and the REPs.
    function automatic logic [7:0] legacy_prefix(input int idx);
        logic [7:0] b;
        case (idx)
            0:       b = 8'h26;
            1:       b = 8'h2E;
            2:       b = 8'h36;
            3:       b = 8'h3E;
            4:       b = 8'h64;
            5:       b = 8'h65;
            6:       b = 8'h66;
            7:       b = 8'h67;
            8:       b = 8'hF0;
            9:       b = 8'hF2;
            default: b = 8'hF3;
        endcase
        return b;
    endfunction

    function automatic bit prefix_byte(input logic [7:0] b);
        bit hit;
        hit = (b[7:4] == 4'h4);
        for (int k = 0; k < 11; k++) begin
            if (b == legacy_prefix(k)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Second bytes after the escape that are privileged on their own:
    // CLTS, SYSRET, INVD, WBINVD, the control and debug register moves,
    // WRMSR, RDMSR, RDPMC, SYSEXIT and the VMX read/write pair.
    function automatic logic [7:0] listed_second(input int idx);
        logic [7:0] b;
        case (idx)
            0:       b = 8'h06;
            1:       b = 8'h07;
            2:       b = 8'h08;
            3:       b = 8'h09;
            4:       b = 8'h20;
            5:       b = 8'h21;
            6:       b = 8'h22;
            7:       b = 8'h23;
            8:       b = 8'h30;
            9:       b = 8'h32;
            10:      b = 8'h33;
            11:      b = 8'h35;
            12:      b = 8'h78;
            default: b = 8'h79;
        endcase
        return b;
    endfunction

    function automatic bit escape_second_privileged(input logic [7:0] b);
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < 14; k++) begin
            if (b == listed_second(k)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Whole third bytes of the 0F 01 group that are privileged whatever
    // their ModRM reg field says (VMX and SWAPGS style encodings).
    function automatic logic [7:0] grp7_listed(input int idx);
        logic [7:0] b;
        case (idx)
            0:       b = 8'hC1;
            1:       b = 8'hC2;
            2:       b = 8'hC3;
            3:       b = 8'hC4;
            4:       b = 8'hC8;
            5:       b = 8'hC9;
            6:       b = 8'hD1;
            default: b = 8'hF8;
        endcase
        return b;
    endfunction

    function automatic bit group_third_privileged(input logic [7:0] sec, input logic [7:0] b);
        logic [2:0] modrm_r;
        bit         hit;
        modrm_r = b[5:3];
        hit     = 1'b0;
        if (sec == x86pod_pkg::OP2_GRP6) begin
            hit = (modrm_r == 3'd2) || (modrm_r == 3'd3);
        end else if (sec == x86pod_pkg::OP2_GRP7) begin
            // Reg fields 2, 3, 6 and 7 all have bit 1 set.
            hit = modrm_r[1];
            for (int k = 0; k < 8; k++) begin
                if (b == grp7_listed(k)) begin
                    hit = 1'b1;
                end
            end
        end else if (sec == x86pod_pkg::OP2_ESC38) begin
            hit = (b == 8'h80) || (b == 8'h81);
        end else if (sec == x86pod_pkg::OP2_GRP9) begin
            hit = (modrm_r[2:1] == 2'b11);
        end
        return hit;
    endfunction

    // Advances the local parser by one accepted word. Returns 1 when the
    // word settles a verdict; active tells whether the word was parsed at
    // all rather than ignored while idle.
    function automatic bit predict_word(input logic [7:0] b, input logic s,
                                        output bit active, output x86pod_pkg::t_out_word v);
        bit done;
        done   = 1'b0;
        active = 1'b0;
        v      = '0;
        if (s) begin
            pstate     = PS_OPCODE;
            pfx_seen   = '0;
            esc_second = '0;
            consumed   = '0;
        end
        if (pstate == PS_IDLE) begin
            return 1'b0;
        end
        active   = 1'b1;
        consumed = consumed + 5'd1;
        case (pstate)
            PS_OPCODE: begin
                if (prefix_byte(b)) begin
                    pfx_seen = pfx_seen + 4'd1;
                    if (pfx_seen >= MAX_PFX) begin
                        done                = 1'b1;
                        v.too_many_prefixes = 1'b1;
                    end
                end else if (b == x86pod_pkg::OP_HLT || b == x86pod_pkg::OP_CLI ||
                             b == x86pod_pkg::OP_STI) begin
                    done         = 1'b1;
                    v.privileged = 1'b1;
                end else if (b == x86pod_pkg::OP_ESCAPE) begin
                    pstate = PS_SECOND;
                end else begin
                    done = 1'b1;
                end
            end
            PS_SECOND: begin
                if (escape_second_privileged(b)) begin
                    done         = 1'b1;
                    v.privileged = 1'b1;
                end else if (b == x86pod_pkg::OP2_GRP6 || b == x86pod_pkg::OP2_GRP7 ||
                             b == x86pod_pkg::OP2_ESC38 || b == x86pod_pkg::OP2_GRP9) begin
                    esc_second = b;
                    pstate     = PS_THIRD;
                end else begin
                    done = 1'b1;
                end
            end
            PS_THIRD: begin
                done         = 1'b1;
                v.privileged = group_third_privileged(esc_second, b);
            end
            default: begin
                pstate = PS_IDLE;
            end
        endcase
        if (done) begin
            v.bytes_used = consumed;
            pstate       = PS_IDLE;
        end
        return done;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one word per call, with a random gap in front of it.
    // Valid is only lowered when a gap is taken, so a word that follows
    // straight on keeps valid high with no second assignment in the step.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic s);
        int                    gap;
        bit                    active;
        x86pod_pkg::t_out_word v;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_instr_byte <= b;
        i_start_req  <= s;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sent_words++;
        if (predict_word(b, s, active, v)) begin
            verdict_q.push_back(v);
        end
        if (active) begin
            parsed_words++;
        end
        if (s) begin
            instr_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, or a long counted hold when asked for.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req) begin
            i_out_ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int expected, input int actual);
        errors++;
        $display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, what, expected,
                 actual);
    endtask

    // Every delivered word is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        x86pod_pkg::t_out_word exp_v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result word count (none was due)", 0, 1);
            end else begin
                exp_v = verdict_q.pop_front();
                verdicts_seen++;
                if (exp_v.privileged) begin
                    priv_seen++;
                end
                if (exp_v.too_many_prefixes) begin
                    overflow_seen++;
                end
                if (int'(exp_v.bytes_used) > max_used_seen) begin
                    max_used_seen = int'(exp_v.bytes_used);
                end
                if (o_privileged !== exp_v.privileged) begin
                    report_mismatch("privileged", int'(exp_v.privileged), int'(o_privileged));
                end
                if (o_too_many_prefixes !== exp_v.too_many_prefixes) begin
                    report_mismatch("too_many_prefixes", int'(exp_v.too_many_prefixes),
                                    int'(o_too_many_prefixes));
                end
                if (o_bytes_used !== exp_v.bytes_used) begin
                    report_mismatch("bytes_used", int'(exp_v.bytes_used), int'(o_bytes_used));
                end
            end
        end
    end

    // The run is abandoned when neither channel has moved a word for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d verdicts outstanding",
                         idle_cycles, verdict_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Random instruction builder.
    // ------------------------------------------------------------------
    function automatic logic [7:0] random_prefix();
        int idx;
        idx = $urandom_range(26);
        if (idx < 16) begin
            return 8'h40 + idx[7:0];
        end
        return legacy_prefix(idx - 16);
    endfunction

    // Mostly well-formed instructions with random content, so that the
    // escape and group states are reached often. A few are cut short (the
    // next start then drops them) and some are trailed by stray words that
    // the block should ignore.
    task automatic send_random_instruction();
        logic [7:0] seq[$];
        logic [7:0] sec;
        int         npfx;
        int         pick;
        int         junk;
        pick = $urandom_range(99);
        if (pick < 55) begin
            npfx = 0;
        end else if (pick < 85) begin
            npfx = $urandom_range(3, 1);
        end else if (pick < 92) begin
            npfx = $urandom_range(13, 4);
        end else if (pick < 96) begin
            npfx = MAX_PFX - 1;
        end else begin
            npfx = $urandom_range(MAX_PFX + 1, MAX_PFX);
        end
        for (int k = 0; k < npfx; k++) begin
            seq.push_back(random_prefix());
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(2))
                0:       seq.push_back(x86pod_pkg::OP_HLT);
                1:       seq.push_back(x86pod_pkg::OP_CLI);
                default: seq.push_back(x86pod_pkg::OP_STI);
            endcase
        end else if (pick < 35) begin
            seq.push_back(8'($urandom_range(255)));
        end else begin
            seq.push_back(x86pod_pkg::OP_ESCAPE);
            pick = $urandom_range(99);
            if (pick < 30) begin
                seq.push_back(listed_second($urandom_range(13)));
            end else if (pick < 75) begin
                case ($urandom_range(3))
                    0:       sec = x86pod_pkg::OP2_GRP6;
                    1:       sec = x86pod_pkg::OP2_GRP7;
                    2:       sec = x86pod_pkg::OP2_ESC38;
                    default: sec = x86pod_pkg::OP2_GRP9;
                endcase
                seq.push_back(sec);
                if (sec == x86pod_pkg::OP2_GRP7 && $urandom_range(3) == 0) begin
                    seq.push_back(grp7_listed($urandom_range(7)));
                end else if (sec == x86pod_pkg::OP2_ESC38 && $urandom_range(1) == 0) begin
                    seq.push_back(8'h80 + 8'($urandom_range(1)));
                end else begin
                    seq.push_back(8'($urandom_range(255)));
                end
            end else begin
                seq.push_back(8'($urandom_range(255)));
            end
        end
        if (seq.size() > 1 && $urandom_range(99) < 8) begin
            void'(seq.pop_back());
        end
        if ($urandom_range(99) < 15) begin
            junk = $urandom_range(3, 1);
            repeat (junk) seq.push_back(8'($urandom_range(255)));
        end
        foreach (seq[k]) begin
            send_word(seq[k], k == 0);
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int words);
        int target;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        target             = sent_words + words;
        while (sent_words < target) begin
            send_random_instruction();
        end
    endtask

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // Every opcode class once, byte extremes, idle bytes before the first
    // start and after a verdict, and a restart in the middle of a parse.
    task automatic test_directed_opcodes();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_word(8'hFF, 1'b0);
        send_word(x86pod_pkg::OP_HLT, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(x86pod_pkg::OP_STI, 1'b1);
        send_word(x86pod_pkg::OP_ESCAPE, 1'b1);
        send_word(x86pod_pkg::OP_CLI, 1'b1);
        send_word(x86pod_pkg::OP_ESCAPE, 1'b1);
        send_word(8'h79, 1'b0);
        send_word(x86pod_pkg::OP_ESCAPE, 1'b1);
        send_word(8'hA2, 1'b0);
        send_word(x86pod_pkg::OP_ESCAPE, 1'b1);
        send_word(x86pod_pkg::OP2_GRP7, 1'b0);
        send_word(8'hF8, 1'b0);
        send_word(x86pod_pkg::OP_ESCAPE, 1'b1);
        send_word(x86pod_pkg::OP2_GRP6, 1'b0);
        send_word(8'hD8, 1'b0);
        send_word(x86pod_pkg::OP_ESCAPE, 1'b1);
        send_word(x86pod_pkg::OP2_ESC38, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(x86pod_pkg::OP_ESCAPE, 1'b1);
        send_word(x86pod_pkg::OP2_GRP9, 1'b0);
        send_word(8'hF8, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // Fifteen prefixes end the instruction with the overflow flag; the
    // word after it belongs to no instruction and is ignored.
    task automatic test_prefix_overflow();
        send_word(8'h40, 1'b1);
        for (int k = 0; k < MAX_PFX - 2; k++) begin
            send_word(legacy_prefix(k % 11), 1'b0);
        end
        send_word(8'h4F, 1'b0);
        send_word(x86pod_pkg::OP_HLT, 1'b0);
    endtask

    // The receiver holds off for a long counted stretch while the sender
    // keeps offering one-word instructions, so the output register and the
    // input register both fill and the block lowers its input ready.
    task automatic test_output_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_req           = 1'b1;
        for (int k = 0; k < 12; k++) begin
            send_word(k[0] ? x86pod_pkg::OP_CLI : 8'hC3, 1'b1);
        end
    endtask

    task automatic finish_run();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d instructions (%0d parsed words) under four idling mixes and a",
                 instr_count, parsed_words);
        $display("long output hold: %0d verdicts, %0d privileged, %0d overflows, longest %0d",
                 verdicts_seen, priv_seen, overflow_seen, max_used_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_opcodes();
        test_prefix_overflow();
        test_output_backpressure();
        run_random_phase(0, 0, PHASE_WORDS);
        run_random_phase(85, 0, PHASE_WORDS);
        run_random_phase(0, 85, PHASE_WORDS);
        run_random_phase(11, 11, PHASE_WORDS);
        finish_run();
    end

endmodule
